// ===== hw/rtl/imu_sample_conditioning_core_macros.svh =====
// Assertion macros shared by the conditioning core.
`ifndef IMU_SAMPLE_CONDITIONING_CORE_MACROS_SVH
`define IMU_SAMPLE_CONDITIONING_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ISC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isc assertion failed");

// Next-cycle implication, checked outside reset.
`define ISC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isc assertion failed");

`endif

// ===== hw/rtl/isc_pkg.sv =====
// Shared types, constants and lane setup for the IMU sample conditioning core.
`timescale 1ns / 1ps

package isc_pkg;

    localparam int NUM_LANES  = 6;
    localparam int NUM_ACCEL  = 3;
    localparam int RAW_W      = 12;
    localparam int OFFSET_W   = 17;
    localparam int LIMIT_W    = 16;
    localparam int OUT_W      = 29;
    localparam int TALLY_W    = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 280;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 3'd6;

    localparam logic [LIMIT_W-1:0] CLAMP_LIMIT_RESET = 16'd14400;

    localparam logic [RAW_W-1:0] BIAS_GYRO  = 12'd1658;
    localparam logic [RAW_W-1:0] BIAS_ACCEL = 12'd2041;

    localparam logic [15:0] GYRO_GAIN_X = 16'd457;
    localparam logic [15:0] GYRO_GAIN_Y = 16'd457;
    localparam logic [15:0] GYRO_GAIN_Z = 16'd457;
    localparam logic [15:0] ACCEL_GAIN  = 16'd1516;

    // low-pass weights in Q.16, sum to 1.0
    localparam logic signed [16:0] LP_OLD   = 17'sd64225;
    localparam logic signed [11:0] LP_NEW   = 12'sd1311;
    localparam logic signed [46:0] LP_ROUND = 47'sd32768;

    typedef struct packed {
        logic [RAW_W-1:0] bias;
        logic             neg;
        logic [15:0]      gain;
    } lane_cfg_t;

    localparam lane_cfg_t LANE_CFG [NUM_LANES] = '{
        '{bias: BIAS_GYRO,  neg: 1'b0, gain: GYRO_GAIN_X},
        '{bias: BIAS_GYRO,  neg: 1'b1, gain: GYRO_GAIN_Y},
        '{bias: BIAS_GYRO,  neg: 1'b1, gain: GYRO_GAIN_Z},
        '{bias: BIAS_ACCEL, neg: 1'b0, gain: ACCEL_GAIN},
        '{bias: BIAS_ACCEL, neg: 1'b1, gain: ACCEL_GAIN},
        '{bias: BIAS_ACCEL, neg: 1'b1, gain: ACCEL_GAIN}
    };

    // one strobe per processing step
    typedef struct packed {
        logic load;
        logic scale;
        logic filt;
        logic commit;
    } ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_FILT,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/isc_lane.sv =====
// One channel lane: bias removal, offset, clamp, then gain multiply.
`timescale 1ns / 1ps

module isc_lane
    import isc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      ctrl,
    input  lane_cfg_t                  cfg,
    input  logic        [RAW_W-1:0]    raw,
    input  logic signed [OFFSET_W-1:0] offset,
    input  logic        [LIMIT_W-1:0]  limit,
    output logic                       clip,
    output logic signed [OUT_W-1:0]    scaled
);

    logic signed [13:0]   diff;
    logic signed [18:0]   d_q4;
    logic signed [18:0]   off_ext;
    logic signed [18:0]   lim_ext;
    logic signed [18:0]   neg_lim;
    logic signed [18:0]   v;
    logic                 over;
    logic                 under;
    logic signed [16:0]   v_next;
    logic signed [16:0]   v_reg;
    logic                 clip_reg;
    logic signed [33:0]   prod_full;
    logic signed [32:0]   prod_reg;
    logic signed [32:0]   rounded;

    always_comb
    begin
        diff    = $signed({2'b00, raw}) - $signed({2'b00, cfg.bias});
        d_q4    = {diff[13], diff, 4'b0000};
        off_ext = {{2{offset[OFFSET_W-1]}}, offset};
        lim_ext = {3'b000, limit};
        neg_lim = -lim_ext;
        v       = cfg.neg ? (off_ext - d_q4) : (d_q4 - off_ext);
        over    = v > lim_ext;
        under   = v < neg_lim;
        if (over)
        begin
            v_next = lim_ext[16:0];
        end
        else if (under)
        begin
            v_next = neg_lim[16:0];
        end
        else
        begin
            v_next = v[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            clip_reg <= over | under;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= v_next;
        end
        if (ctrl.scale)
        begin
            prod_reg <= prod_full[32:0];
        end
    end

    assign prod_full = v_reg * $signed({1'b0, cfg.gain});

    // round half up, then floor by 16
    assign rounded = prod_reg + 33'sd8;
    assign scaled  = rounded[32:4];
    assign clip    = clip_reg;

endmodule

// ===== hw/rtl/isc_lowpass.sv =====
// First-order low-pass for one accelerometer axis, 0.98 old + 0.02 new.
`timescale 1ns / 1ps

module isc_lowpass
    import isc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  logic signed [OUT_W-1:0] sample,
    output logic signed [OUT_W-1:0] smooth_next
);

    logic signed [OUT_W-1:0] store_reg;
    logic signed [45:0]      old_prod;
    logic signed [40:0]      new_prod;
    logic signed [45:0]      old_reg;
    logic signed [40:0]      new_reg;
    logic signed [46:0]      sum;

    assign old_prod = store_reg * LP_OLD;
    assign new_prod = sample * LP_NEW;

    always_ff @(posedge clk)
    begin
        if (ctrl.filt)
        begin
            old_reg <= old_prod;
            new_reg <= new_prod;
        end
    end

    assign sum = {old_reg[45], old_reg} + {{6{new_reg[40]}}, new_reg} + LP_ROUND;
    // filter output stays between old and new, so 29 bits after the shift hold it
    assign smooth_next = sum[44:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            store_reg <= smooth_next;
        end
    end

endmodule

// ===== hw/rtl/isc_merge.sv =====
// Merge stage: clamp tally and the registered output request.
`timescale 1ns / 1ps

module isc_merge
    import isc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_t                   ctrl,
    input  logic [NUM_LANES-1:0]    clip,
    input  logic signed [OUT_W-1:0] scaled [NUM_LANES],
    input  logic signed [OUT_W-1:0] smooth [NUM_ACCEL],
    output logic                    out_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata
);

    logic [TALLY_W-1:0]    tally_reg;
    logic [TALLY_W-1:0]    tally_next;
    logic [2:0]            clip_cnt;
    logic [TALLY_W:0]      tally_sum;
    logic                  valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;
    logic [OUT_DATA_W-1:0] data_next;

    always_comb
    begin
        clip_cnt = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            clip_cnt = clip_cnt + {2'b00, clip[i]};
        end
        tally_sum  = {1'b0, tally_reg} + {{(TALLY_W-2){1'b0}}, clip_cnt};
        tally_next = tally_sum[TALLY_W] ? {TALLY_W{1'b1}} : tally_sum[TALLY_W-1:0];
    end

    always_comb
    begin
        data_next = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            data_next[i*OUT_W +: OUT_W] = scaled[i];
        end
        for (int j = 0; j < NUM_ACCEL; j++)
        begin
            data_next[(NUM_LANES+j)*OUT_W +: OUT_W] = smooth[j];
        end
        data_next[(NUM_LANES+NUM_ACCEL)*OUT_W +: TALLY_W] = tally_next;
    end

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            tally_reg <= tally_next;
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ===== hw/rtl/imu_sample_conditioning_core.sv =====
// Top level of the IMU sample conditioning core: config, sequencer and lanes.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | six raw 12-bit ADC readings
//  m_*     | out | m_tvalid/m_tready  | rates, accels, smoothed accels, tally
//  cfg_*   | in  | cfg_valid/cfg_ready| register index and write data
//
// Each sample passes these steps: clamp in all six lanes at accept, gain multiply,
// filter products, filter sum into the output register. The four sequencer
// steps run with one sample in flight at a time.
// Reset returns offsets to 0, limit to 14400, filter state and tally to 0.
// The sequencer holds its last step while the output request is not taken.
`timescale 1ns / 1ps

`include "imu_sample_conditioning_core_macros.svh"

module imu_sample_conditioning_core
    import isc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // raw_gyro_x, raw_gyro_y, raw_gyro_z, raw_accel_x, raw_accel_y, raw_accel_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // rate_x/y/z, accel_out_x/y/z, smooth_x/y/z, clamp_events, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [OFFSET_W-1:0]   cfg_data
);

    state_t                     state_reg;
    state_t                     state_next;
    ctrl_t                      ctrl;
    logic                       out_free;
    logic signed [OFFSET_W-1:0] offset_reg [NUM_LANES];
    logic [LIMIT_W-1:0]         limit_reg;
    logic [NUM_LANES-1:0]       clip;
    logic signed [OUT_W-1:0]    scaled [NUM_LANES];
    logic signed [OUT_W-1:0]    smooth [NUM_ACCEL];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                offset_reg[i] <= '0;
            end
            limit_reg <= CLAMP_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index <= CFG_OFFSET_LAST)
            begin
                offset_reg[cfg_index] <= cfg_data;
            end
            else if (cfg_index == CFG_CLAMP_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                ctrl.scale = 1'b1;
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                ctrl.filt  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                ctrl.commit = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        isc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .cfg    (LANE_CFG[g]),
            .raw    (s_tdata[g*RAW_W +: RAW_W]),
            .offset (offset_reg[g]),
            .limit  (limit_reg),
            .clip   (clip[g]),
            .scaled (scaled[g])
        );
    end

    for (genvar a = 0; a < NUM_ACCEL; a++)
    begin : g_lp
        isc_lowpass u_lp (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sample      (scaled[NUM_LANES-NUM_ACCEL+a]),
            .smooth_next (smooth[a])
        );
    end

    isc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .clip     (clip),
        .scaled   (scaled),
        .smooth   (smooth),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `ISC_ASSERT_NEXT(a_commit_shows, ctrl.commit, m_tvalid)
    `ISC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `ISC_ASSERT_NOW(a_one_step, 1'b1, $onehot0({ctrl.load, ctrl.scale, ctrl.filt, ctrl.commit}))

endmodule

// ===== sim/imu_sample_conditioning_core_tb.sv =====
// Self-checking testbench for the IMU sample conditioning core.
`timescale 1ns / 1ps

module imu_sample_conditioning_core_tb;
    import isc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_GYRO_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED      = 3'd7;
    localparam logic [NUM_LANES-1:0] NEG_LANES         = 6'b110110;
    localparam int                   LIMIT_MAX         = 65520;
    localparam int                   ITEMS_PER_PHASE   = 200;
    localparam int                   NUM_PHASES        = 6;
    localparam int                   FILL_ITEMS        = 40;
    localparam int                   QUIET_LIMIT       = 1000;
    localparam int                   SETTLE_CYCLES     = 16;

    typedef struct packed {
        logic [TALLY_W-1:0]          events;
        logic [8:0][OUT_W-1:0]       lane;
    } sample_result_t;

    // Tracks offsets, limit, filter state and clamp tally; predicts every result.
    class conditioning_scoreboard;
        sample_result_t expected_q[$];
        longint         offset[NUM_LANES];
        longint         gain[NUM_LANES];
        longint         limit;
        int             smooth[NUM_ACCEL];
        logic [15:0]    tally;
        int             errors;
        int             checked;
        string          lane_names[9] = '{"rate_x", "rate_y", "rate_z",
                                          "accel_out_x", "accel_out_y", "accel_out_z",
                                          "smooth_x", "smooth_y", "smooth_z"};

        function new();
            for (int i = 0; i < NUM_LANES; i++)
                offset[i] = 0;
            for (int i = 0; i < NUM_ACCEL; i++)
                smooth[i] = 0;
            gain[0] = longint'(GYRO_GAIN_X);
            gain[1] = longint'(GYRO_GAIN_Y);
            gain[2] = longint'(GYRO_GAIN_Z);
            for (int i = NUM_ACCEL; i < NUM_LANES; i++)
                gain[i] = longint'(ACCEL_GAIN);
            limit   = longint'(CLAMP_LIMIT_RESET);
            tally   = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFFSET_W-1:0] data);
            if (idx <= CFG_OFFSET_LAST)
                offset[idx] = longint'($signed(data));
            else if (idx == CFG_CLAMP_LIMIT)
                limit = longint'(data[LIMIT_W-1:0]);
        endfunction

        function longint bias_of(int ch);
            return (ch < NUM_ACCEL) ? longint'(BIAS_GYRO) : longint'(BIAS_ACCEL);
        endfunction

        // bias removal, signed offset, clamp; bumps the tally on a clamp
        function longint correct_lane(int ch, logic [RAW_W-1:0] raw);
            longint d;
            longint v;
            d = (longint'(raw) - bias_of(ch)) * 16;
            v = NEG_LANES[ch] ? offset[ch] - d : d - offset[ch];
            if (v > limit || v < -limit) begin
                if (tally != 16'hFFFF)
                    tally++;
                v = (v > 0) ? limit : -limit;
            end
            return v;
        endfunction

        function void note_sample(logic [IN_DATA_W-1:0] d);
            sample_result_t exp_res;
            longint         scaled[NUM_LANES];
            longint         acc;
            for (int ch = 0; ch < NUM_LANES; ch++) begin
                scaled[ch] = (correct_lane(ch, d[ch*RAW_W +: RAW_W]) * gain[ch] + 8) >>> 4;
                exp_res.lane[ch] = scaled[ch][OUT_W-1:0];
            end
            for (int i = 0; i < NUM_ACCEL; i++) begin
                acc = longint'(smooth[i]) * longint'(LP_OLD)
                    + scaled[NUM_ACCEL+i] * longint'(LP_NEW) + longint'(LP_ROUND);
                smooth[i] = int'(acc >>> 16);
                exp_res.lane[NUM_LANES+i] = smooth[i][OUT_W-1:0];
            end
            exp_res.events = tally;
            expected_q.push_back(exp_res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH result %0d @%0t: %s", checked, $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_DATA_W-1:0] d);
            sample_result_t got;
            sample_result_t want;
            got = sample_result_t'(d[$bits(sample_result_t)-1:0]);
            if (expected_q.size() == 0) begin
                report_mismatch("result with no sample outstanding");
            end
            else begin
                want = expected_q.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.lane[i] !== want.lane[i])
                        report_mismatch($sformatf("%s got %0d want %0d", lane_names[i],
                            $signed(got.lane[i]), $signed(want.lane[i])));
                if (got.events !== want.events)
                    report_mismatch($sformatf("clamp_events got %0d want %0d",
                        got.events, want.events));
            end
            if (d[OUT_DATA_W-1:$bits(sample_result_t)] !== '0)
                report_mismatch("pad bits not zero");
            checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [OFFSET_W-1:0]   cfg_data;

    conditioning_scoreboard sb = new();
    int send_calm = 0;
    int recv_calm = 0;
    int n_sent = 0;
    int n_writes = 0;

    imu_sample_conditioning_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // idle cycles before the next request; runs of zero now and then
    function automatic int draw_idle(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_raw(int g0, int g1, int g2,
                                                      int a0, int a1, int a2);
        return {a2[RAW_W-1:0], a1[RAW_W-1:0], a0[RAW_W-1:0],
                g2[RAW_W-1:0], g1[RAW_W-1:0], g0[RAW_W-1:0]};
    endfunction

    // mostly uniform, with extremes, zero-correction and clamp-edge readings
    function automatic logic [RAW_W-1:0] pick_raw(int ch);
        longint target;
        longint d;
        longint r;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return RAW_W'(sb.bias_of(ch) + (sb.offset[ch] / 16));
            3, 4:
            begin
                target = $urandom_range(0, 1) ? sb.limit : -sb.limit;
                d = NEG_LANES[ch] ? sb.offset[ch] - target : target + sb.offset[ch];
                if (d % 16 == 0) begin
                    r = sb.bias_of(ch) + d / 16 + longint'($urandom_range(0, 2)) - 1;
                    if (r >= 0 && r <= 4095)
                        return RAW_W'(r);
                end
                return RAW_W'($urandom_range(0, 4095));
            end
            default: return RAW_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task send_sample(logic [IN_DATA_W-1:0] d);
        int gap;
        gap = draw_idle(send_calm);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge clk); while (!s_tready);
        sb.note_sample(d);
        n_sent++;
        @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [OFFSET_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        n_writes++;
        @(negedge clk);
    endtask

    task wait_idle();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task program_phase(int k);
        int          off;
        logic [15:0] lim;
        for (int r = REG_OFFSET_GYRO_X; r <= CFG_OFFSET_LAST; r++) begin
            case (k)
                1:       off = LIMIT_MAX;
                2:       off = -LIMIT_MAX;
                0, 6:    off = 0;
                default:
                    if ($urandom_range(0, 1))
                        off = (int'($urandom_range(0, 8190)) - 4095) * 16;
                    else
                        off = int'($urandom_range(0, 2 * LIMIT_MAX)) - LIMIT_MAX;
            endcase
            write_cfg(CFG_IDX_W'(r), off[OFFSET_W-1:0]);
        end
        case (k)
            0, 2:    lim = 16'(LIMIT_MAX);
            3:       lim = 16'($urandom_range(0, 2000));
            5:       lim = CLAMP_LIMIT_RESET;
            6:       lim = '0;
            default: lim = 16'($urandom_range(0, LIMIT_MAX));
        endcase
        write_cfg(CFG_CLAMP_LIMIT, {1'b0, lim});
        cfg_valid = 1'b0;
    endtask

    // result side: random stalls, every accepted result checked
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = draw_idle(recv_calm);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata);
            @(negedge clk);
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.expected_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: extremes, zero correction, both clamp edges per lane
        send_sample(pack_raw(0, 0, 0, 0, 0, 0));
        send_sample(pack_raw(4095, 4095, 4095, 4095, 4095, 4095));
        send_sample(pack_raw(BIAS_GYRO, BIAS_GYRO, BIAS_GYRO,
                             BIAS_ACCEL, BIAS_ACCEL, BIAS_ACCEL));
        send_sample(pack_raw(2558, 758, 758, 2941, 1141, 1141));
        send_sample(pack_raw(2559, 757, 757, 2942, 1140, 1140));
        send_sample(pack_raw(758, 2558, 2558, 1141, 2941, 2941));
        send_sample(pack_raw(757, 2559, 2559, 1140, 2942, 2942));
        send_sample(pack_raw('h555, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAA));
        send_sample(pack_raw('hAAA, 'h555, 'hAAA, 'h555, 'hAAA, 'h555));

        // zero limit: anything nonzero clamps; unused index must not disturb it
        wait_idle();
        write_cfg(CFG_CLAMP_LIMIT, '0);
        write_cfg(REG_RESERVED, OFFSET_W'($urandom_range(0, 131071)));
        cfg_valid = 1'b0;
        send_sample(pack_raw(BIAS_GYRO, BIAS_GYRO, BIAS_GYRO,
                             BIAS_ACCEL, BIAS_ACCEL, BIAS_ACCEL));
        send_sample(pack_raw(BIAS_GYRO + 1, BIAS_GYRO + 1, BIAS_GYRO + 1,
                             BIAS_ACCEL + 1, BIAS_ACCEL + 1, BIAS_ACCEL + 1));
        send_sample(pack_raw(BIAS_GYRO - 1, BIAS_GYRO - 1, BIAS_GYRO - 1,
                             BIAS_ACCEL - 1, BIAS_ACCEL - 1, BIAS_ACCEL - 1));
        send_sample(pack_raw(0, 4095, 0, 4095, 0, 4095));

        for (int k = 0; k < NUM_PHASES; k++) begin
            wait_idle();
            program_phase(k);
            repeat (ITEMS_PER_PHASE)
                send_sample(pack_raw(pick_raw(0), pick_raw(1), pick_raw(2),
                                     pick_raw(3), pick_raw(4), pick_raw(5)));
        end

        // zero limit, no offsets, readings far from bias: every channel clamps
        wait_idle();
        program_phase(NUM_PHASES);
        repeat (FILL_ITEMS)
            send_sample(pack_raw(
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095),
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095),
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095),
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095),
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095),
                $urandom_range(0, 1) ? $urandom_range(0, 1000) : $urandom_range(3000, 4095)));

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d samples over %0d register settings (%0d writes), %0d results",
                 n_sent, NUM_PHASES + 3, n_writes, sb.checked);
        $display("final clamp tally %0d, %0d mismatches", sb.tally, sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/isc_pkg.sv
hw/rtl/isc_lane.sv
hw/rtl/isc_lowpass.sv
hw/rtl/isc_merge.sv
hw/rtl/imu_sample_conditioning_core.sv
sim/imu_sample_conditioning_core_tb.sv
